// ===== hw/rtl/tccw_pkg.sv =====
// Shared types, codes and tables of the text console cursor writer.
`timescale 1ns / 1ps

package tccw_pkg;

  // Screen geometry and tab spacing
  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int TAB_STOP    = 8;
  localparam int MAX_RESULTS = 12;

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int TAB_W  = 5;   // holds a fill count of 1 .. TAB_STOP
  localparam int EMIT_W = 4;   // holds a result count of 0 .. MAX_RESULTS
  localparam int COL_DEPTH = 1 << COL_W;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [TAB_W-1:0]  tab_cnt_t;
  typedef logic [EMIT_W-1:0] emit_cnt_t;

  // Character codes with special handling
  localparam char_t CODE_TAB   = 8'd9;
  localparam char_t CODE_NL    = 8'd10;
  localparam char_t CODE_CR    = 8'd13;
  localparam char_t CODE_SPACE = 8'd32;

  localparam attr_t ATTR_RESET = 8'd15;

  // Event kinds
  localparam logic EV_WRITE  = 1'b0;
  localparam logic EV_SCROLL = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch a new character
    logic head;   // wrap, scroll and apply the character's own action
    logic put;    // place one code (a printable or one tab space)
  } tccw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic stall;        // result slot busy, step cannot complete
    logic scroll;       // this step emits a scroll instead of a write
    logic is_nl;
    logic is_cr;
    logic remain_last;  // one code left to place
  } tccw_status_t;

  // Spaces a tab inserts, indexed by column
  typedef tab_cnt_t tab_rom_t [0:COL_DEPTH-1];

  function automatic tab_rom_t build_tab_rom();
    tab_rom_t rom;
    for (int i = 0; i < COL_DEPTH; i++) begin
      rom[i] = TAB_W'(TAB_STOP - (i % TAB_STOP));
    end
    return rom;
  endfunction

  localparam tab_rom_t TAB_ROM = build_tab_rom();

endpackage

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller state machine of the text console cursor writer.
`timescale 1ns / 1ps

module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output tccw_cmd_t    cmd,
  input  tccw_status_t st
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_PUT
  } state_t;

  state_t state;

  // Accept a character only when no work is in flight
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && (state == S_IDLE);
    cmd.head = (state == S_HEAD);
    cmd.put  = (state == S_PUT);
  end

  // Sequence one character: head step, then one put step per code (none for newline or CR)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_HEAD;
        end
        S_HEAD: begin
          if (!st.stall) begin
            if (st.is_nl || st.is_cr) state <= S_IDLE;
            else                      state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!st.stall && !st.scroll && st.remain_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A put step that places the last code returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && !st.stall && !st.scroll && st.remain_last) |=> in_ready)
    else $error("controller did not finish after last code");

  // Newline and carriage return never enter the put phase
  assert property (@(posedge clk) disable iff (rst)
    (state == S_HEAD && !st.stall && (st.is_nl || st.is_cr)) |=> (state == S_IDLE))
    else $error("control character entered put phase");

  // Only one step command at a time
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.head, cmd.put}))
    else $error("overlapping datapath commands");

endmodule

// ===== hw/rtl/tccw_dp.sv =====
// Datapath of the text console cursor writer: cursor, tab count and result register.
`timescale 1ns / 1ps

module tccw_dp
  import tccw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  char_t        char_in,
  input  logic         cfg_we,
  input  attr_t        cfg_attr,
  input  tccw_cmd_t    cmd,
  output tccw_status_t st,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         event_kind,
  output row_t         cell_row,
  output col_t         cell_col,
  output char_t        cell_char,
  output attr_t        cell_attr,
  output logic         last_of_run
);

  char_t     ch;
  row_t      row;
  col_t      col;
  tab_cnt_t  remain;
  emit_cnt_t emit_cnt;
  attr_t     attr;

  logic  wrap, scroll, is_tab, is_nl, is_cr;
  row_t  w_row, s_row;
  col_t  w_col;
  logic  emit_want, capped, out_free, stall, step, emit, emit_last;
  logic  nth_last;
  char_t put_char;

  // Decode the latched character
  assign is_tab = (ch == CODE_TAB);
  assign is_nl  = (ch == CODE_NL);
  assign is_cr  = (ch == CODE_CR);
  assign put_char = is_tab ? CODE_SPACE : ch;

  // Wrap a full line, then check for a row past the bottom
  assign wrap   = (col >= COL_W'(SCREEN_COLS));
  assign w_row  = wrap ? row + 1'b1 : row;
  assign w_col  = wrap ? '0 : col;
  assign scroll = (w_row >= ROW_W'(SCREEN_ROWS));
  assign s_row  = scroll ? ROW_W'(SCREEN_ROWS - 1) : w_row;

  // Result slot handling; results past the cap are dropped
  assign emit_want = (cmd.head && scroll) || cmd.put;
  assign capped    = (emit_cnt == EMIT_W'(MAX_RESULTS));
  assign out_free  = !out_valid || out_ready;
  assign stall     = emit_want && !capped && !out_free;
  assign step      = (cmd.head || cmd.put) && !stall;
  assign emit      = step && emit_want && !capped;
  assign nth_last  = (emit_cnt == EMIT_W'(MAX_RESULTS - 1));

  always_comb begin
    if (cmd.head) emit_last = is_nl || is_cr || nth_last;
    else          emit_last = (!scroll && remain == TAB_W'(1)) || nth_last;
  end

  assign st.stall       = stall;
  assign st.scroll      = scroll;
  assign st.is_nl       = is_nl;
  assign st.is_cr       = is_cr;
  assign st.remain_last = (remain == TAB_W'(1));

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst)         attr <= ATTR_RESET;
    else if (cfg_we) attr <= cfg_attr;
  end

  // Cursor, tab count and result count
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      remain   <= '0;
      emit_cnt <= '0;
      ch       <= '0;
    end else begin
      if (cmd.load) begin
        ch       <= char_in;
        emit_cnt <= '0;
      end else if (step) begin
        if (emit) emit_cnt <= emit_cnt + 1'b1;
        if (cmd.head) begin
          priority if (is_nl) begin
            row <= s_row + 1'b1;
            col <= '0;
          end else if (is_cr) begin
            row <= s_row;
            col <= '0;
          end else if (is_tab) begin
            row    <= s_row;
            col    <= w_col;
            remain <= TAB_ROM[w_col];
          end else begin
            row    <= s_row;
            col    <= w_col;
            remain <= TAB_W'(1);
          end
        end else if (scroll) begin
          row <= s_row;
          col <= w_col;
        end else begin
          row    <= w_row;
          col    <= w_col + 1'b1;
          remain <= remain - 1'b1;
        end
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (emit)      out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      last_of_run <= emit_last;
      if (scroll) begin
        event_kind <= EV_SCROLL;
        cell_row   <= '0;
        cell_col   <= '0;
        cell_char  <= '0;
        cell_attr  <= '0;
      end else begin
        event_kind <= EV_WRITE;
        cell_row   <= w_row;
        cell_col   <= w_col;
        cell_char  <= put_char;
        cell_attr  <= attr;
      end
    end
  end

  // Never more results than the cap
  assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= EMIT_W'(MAX_RESULTS))
    else $error("result count above cap");

  // Cursor stays within the screen plus one pending row or column
  assert property (@(posedge clk) disable iff (rst)
    (col <= COL_W'(SCREEN_COLS)) && (row <= ROW_W'(SCREEN_ROWS)))
    else $error("cursor out of range");

  // A scroll result carries zero cell fields
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_SCROLL) |-> (cell_row == '0 && cell_col == '0))
    else $error("scroll event with cell position");

  // A written cell lies on the screen
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_WRITE) |->
      (cell_row < ROW_W'(SCREEN_ROWS) && cell_col < COL_W'(SCREEN_COLS)))
    else $error("cell write off screen");

endmodule

// ===== hw/rtl/text_console_cursor_writer.sv =====
// Top level of the text console cursor writer.
//
//  channel   | signals                              | transfer when
//  ----------+--------------------------------------+------------------------------
//  input     | s_axis_tvalid/tready/tdata           | s_axis_tvalid && s_axis_tready
//  result    | m_axis_tvalid/tready/tdata/tuser/tlast | m_axis_tvalid && m_axis_tready
//  config    | cfg_valid/cfg_ready/cfg_data         | cfg_valid && cfg_ready
//
// A character takes its accept step, one head step and one put step per placed code;
// newline and carriage return have no put step, and a tab places the spaces up to the
// next tab stop. A scroll at the head shares the head step; a wrap and scroll in the
// middle of a tab takes an extra put step, which emits the scroll.
// The controller sequences one character at a time; the next is accepted once
// the last step has completed, and the result register decouples the result side.
// A stalled result register holds the step in progress. rst is synchronous,
// clears the cursor to the top left and the attribute to 15. Config is always ready.
`timescale 1ns / 1ps

module text_console_cursor_writer
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [4:0] cell_row, [11:5] cell_col,
                                      // [19:12] cell_char, [27:20] cell_attr
  output logic        m_axis_tuser,   // [0] event_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // [7:0] text_attribute
);

  tccw_cmd_t    cmd;
  tccw_status_t st;
  row_t         cell_row;
  col_t         cell_col;
  char_t        cell_char;
  attr_t        cell_attr;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .st       (st)
  );

  tccw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .char_in     (s_axis_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_attr    (cfg_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .event_kind  (m_axis_tuser),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_char   (cell_char),
    .cell_attr   (cell_attr),
    .last_of_run (m_axis_tlast)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {4'b0000, cell_attr, cell_char, cell_col, cell_row};

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the text console cursor writer: streams characters, checks cell events.
`timescale 1ns / 1ps

module tb;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic  kind;
    row_t  row;
    col_t  col;
    char_t code;
    attr_t attr;
    logic  last;
  } cell_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] char_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [4:0] row, [11:5] col, [19:12] char, [27:20] attr
  logic        m_axis_tuser;         // [0] event_kind
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;        // [7:0] text_attribute

  // Characters waiting to be sent and cell events still owed by the block
  char_t       char_backlog[$];
  cell_event_t cell_events[$];

  // Cursor and attribute as the block should hold them
  row_t  cur_row = '0;
  col_t  cur_col = '0;
  attr_t text_attr = ATTR_RESET;
  int    events_this_char;

  int    errors = 0;
  int    cycle_count = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    rdy_hold = 0;

  text_console_cursor_writer u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Queue one expected event; results past the per-character cap are dropped
  function automatic void push_event(logic kind, row_t row, col_t col, char_t code, attr_t attr);
    cell_event_t ev;
    if (events_this_char < MAX_RESULTS) begin
      ev.kind = kind;
      ev.row  = row;
      ev.col  = col;
      ev.code = code;
      ev.attr = attr;
      ev.last = 1'b0;
      cell_events.push_back(ev);
      events_this_char++;
    end
  endfunction

  // Wrap a full line, then scroll if the cursor sits below the screen
  function automatic void wrap_cursor();
    if (cur_col >= SCREEN_COLS) begin
      cur_row = cur_row + 1'b1;
      cur_col = '0;
    end
    if (cur_row >= SCREEN_ROWS) begin
      push_event(EV_SCROLL, '0, '0, '0, '0);
      cur_row = row_t'(SCREEN_ROWS - 1);
    end
  endfunction

  function automatic void put_code(char_t code);
    wrap_cursor();
    push_event(EV_WRITE, cur_row, cur_col, code, text_attr);
    cur_col = cur_col + 1'b1;
  endfunction

  // Work out every cell event one accepted character causes
  function automatic void place_char(char_t code);
    int spaces;
    events_this_char = 0;
    case (code)
      CODE_TAB: begin
        wrap_cursor();
        spaces = TAB_STOP - (int'(cur_col) % TAB_STOP);
        for (int i = 0; i < spaces; i++) put_code(CODE_SPACE);
      end
      CODE_NL: begin
        wrap_cursor();
        cur_row = cur_row + 1'b1;
        cur_col = '0;
      end
      CODE_CR: begin
        wrap_cursor();
        cur_col = '0;
      end
      default: put_code(code);
    endcase
    if (events_this_char > 0) cell_events[cell_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // Pick one character: text most of the time, control codes and raw bytes mixed in
  function automatic char_t pick_char(int nl_pct, int tab_pct, int cr_pct, int noise_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < nl_pct) return CODE_NL;
    if (roll < nl_pct + tab_pct) return CODE_TAB;
    if (roll < nl_pct + tab_pct + cr_pct) return CODE_CR;
    if (roll < nl_pct + tab_pct + cr_pct + noise_pct) return char_t'($urandom_range(0, 255));
    return char_t'($urandom_range(32, 126));
  endfunction

  task automatic queue_text(int count, int nl_pct, int tab_pct, int cr_pct, int noise_pct);
    @(negedge clk);
    for (int i = 0; i < count; i++)
      char_backlog.push_back(pick_char(nl_pct, tab_pct, cr_pct, noise_pct));
  endtask

  // Wait until every character is sent and every event has come back
  task automatic wait_idle();
    while (char_backlog.size() != 0 || s_axis_tvalid || cell_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_attr(attr_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    text_attr = value;
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) void'(char_backlog.pop_front());
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (char_backlog.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= char_backlog[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready runs of random length, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rdy_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
      rdy_hold <= $urandom_range(0, 40);
    end
  end

  // Check each result transfer, then predict for a character accepted at this edge
  always @(posedge clk) begin
    cell_event_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_events.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = cell_events.pop_front();
          check_field("event_kind", want.kind, m_axis_tuser);
          check_field("cell_row",   want.row,  m_axis_tdata[4:0]);
          check_field("cell_col",   want.col,  m_axis_tdata[11:5]);
          check_field("cell_char",  want.code, m_axis_tdata[19:12]);
          check_field("cell_attr",  want.attr, m_axis_tdata[27:20]);
          check_field("last_of_run", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) place_char(s_axis_tdata);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, every control code, tabs from odd and aligned columns
    @(negedge clk);
    char_backlog = '{8'h00, 8'hFF, 8'h41, CODE_TAB, 8'h7F, CODE_CR, CODE_TAB, 8'h80,
                     CODE_NL, CODE_NL, 8'h20, CODE_TAB, CODE_CR, CODE_NL};
    wait_idle();

    // Console text with many newlines
    write_text_attr(8'h00);
    queue_text(106, 18, 10, 6, 10);
    wait_idle();

    // Long lines that wrap at the right edge, mostly through tabs
    write_text_attr(8'hFF);
    queue_text(106, 1, 20, 1, 8);
    wait_idle();

    write_text_attr(attr_t'($urandom_range(0, 255)));
    queue_text(106, 12, 12, 5, 12);
    wait_idle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
